[hw/rtl/nwl_pkg.sv]
package nwl_pkg;

	localparam int unsigned CompW    = 32;
	localparam int unsigned SqW      = 2 * CompW;
	localparam int unsigned RootW    = CompW;
	localparam int unsigned UnitW    = 18;
	localparam int unsigned QuotW    = 17;
	localparam int unsigned FracBits = 16;
	localparam int unsigned ThrW     = 16;
	localparam int unsigned Lanes    = 3;

	// Pipeline depths: square, sum, root, divide.
	localparam int unsigned SqLat    = 1;
	localparam int unsigned SumLat   = 1;
	localparam int unsigned RootLat  = RootW;
	localparam int unsigned DivLat   = FracBits + 1;
	localparam int unsigned PreDiv   = SqLat + SumLat + RootLat;
	localparam int unsigned TotalLat = PreDiv + DivLat;

	localparam logic [ThrW-1:0] ThrReset = 16'd66;

	typedef logic [CompW-1:0] mag_t;

endpackage

[hw/rtl/nwl_square.sv]
module nwl_square (
	input  logic                      clk,
	input  logic                      adv,
	input  logic signed [31:0]        comp,
	output nwl_pkg::mag_t             mag,
	output logic                      neg,
	output logic [63:0]               sq_s1
);
	import nwl_pkg::*;

	// Two's complement magnitude; the most negative value maps to 2^31 unchanged.
	assign neg = comp[CompW-1];
	assign mag = neg ? (~comp + 1'b1) : comp;

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s1 <= SqW'(mag) * SqW'(mag);
		end
	end
endmodule

[hw/rtl/nwl_sqrt.sv]
module nwl_sqrt (
	input  logic        clk,
	input  logic        adv,
	input  logic [63:0] radicand,
	output logic [31:0] root
);
	import nwl_pkg::*;

	logic [RootW+2:0] rem_q [RootLat];
	logic [RootW-1:0] res_q [RootLat];
	logic [SqW-1:0]   rad_q [RootLat];

	// One result bit per stage: bring down two radicand bits, try 4*res+1.
	for (genvar k = 0; k < RootLat; k++) begin : g_stage
		logic [RootW+2:0] rem_in;
		logic [RootW-1:0] res_in;
		logic [SqW-1:0]   rad_in;
		logic [RootW+2:0] r2;
		logic [RootW+2:0] trial;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign res_in = '0;
			assign rad_in = radicand;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign res_in = res_q[k-1];
			assign rad_in = rad_q[k-1];
		end

		assign r2    = {rem_in[RootW:0], rad_in[SqW-1 -: 2]};
		assign trial = {1'b0, res_in, 2'b01};

		always_ff @(posedge clk) begin
			if (adv) begin
				rad_q[k] <= {rad_in[SqW-3:0], 2'b00};
				if (r2 >= trial) begin
					rem_q[k] <= r2 - trial;
					res_q[k] <= {res_in[RootW-2:0], 1'b1};
				end else begin
					rem_q[k] <= r2;
					res_q[k] <= {res_in[RootW-2:0], 1'b0};
				end
			end
		end
	end

	assign root = res_q[RootLat-1];
endmodule

[hw/rtl/nwl_divide.sv]
module nwl_divide (
	input  logic        clk,
	input  logic        adv,
	input  nwl_pkg::mag_t mag,
	input  logic [31:0] len,
	output logic [16:0] quot
);
	import nwl_pkg::*;

	logic [CompW-1:0] rem_q [DivLat];
	logic [CompW-1:0] len_q [DivLat];
	logic [QuotW-1:0] quo_q [DivLat];

	// Restoring division of mag * 2^16 by len. Since mag never exceeds the
	// floored length, the first stage settles the integer bit and the
	// remainder stays below len from then on.
	for (genvar k = 0; k < DivLat; k++) begin : g_stage
		logic [CompW:0]   r2;
		logic [CompW-1:0] d;
		logic [QuotW-1:0] q_in;

		if (k == 0) begin : g_first
			assign r2   = {1'b0, mag};
			assign d    = len;
			assign q_in = '0;
		end else begin : g_next
			assign r2   = {rem_q[k-1], 1'b0};
			assign d    = len_q[k-1];
			assign q_in = quo_q[k-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				len_q[k] <= d;
				if (r2 >= {1'b0, d}) begin
					rem_q[k] <= CompW'(r2 - {1'b0, d});
					quo_q[k] <= {q_in[QuotW-2:0], 1'b1};
				end else begin
					rem_q[k] <= r2[CompW-1:0];
					quo_q[k] <= {q_in[QuotW-2:0], 1'b0};
				end
			end
		end
	end

	assign quot = quo_q[DivLat-1];
endmodule

[hw/rtl/vec3_normalise_with_length.sv]
// Normalizes one signed Q16.16 vector per request and returns the unit vector
// in signed Q1.16 together with its floored Q16.16 length. A new vector is
// taken every cycle while the output is not stalled; each result passes
// through one square stage, one sum stage, a 32-stage bit-per-cycle square root
// and a 17-stage divider in each of the three component lanes, plus the output
// register. Lengths at or below zero_threshold give a zero vector with the
// flag in tuser set. A stalled output holds the whole pipeline.
module vec3_normalise_with_length (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [95:0]  s_axis_tdata,   // vec_x, vec_y, vec_z
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [87:0]  m_axis_tdata,   // unit_x, unit_y, unit_z, vec_length, zero pad
	output logic [0:0]   m_axis_tuser,   // zero_flag
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);
	import nwl_pkg::*;

	logic            adv;
	logic [ThrW-1:0] thr_q;
	logic            vld_q [TotalLat];
	mag_t            mag   [Lanes];
	logic            neg   [Lanes];
	logic [SqW-1:0]  sq_s1 [Lanes];
	logic [SqW-1:0]  sum_s2;
	logic [RootW-1:0] root;
	mag_t            magd_q [PreDiv][Lanes];
	logic            negd_q [TotalLat][Lanes];
	logic [RootW-1:0] lend_q [DivLat];
	logic [QuotW-1:0] quot [Lanes];
	logic [UnitW-1:0] unit_o [Lanes];
	logic            zero_o;
	logic            out_vld_q;
	logic [87:0]     out_data_q;
	logic            out_zero_q;

	assign adv           = !out_vld_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= ThrReset;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	for (genvar l = 0; l < Lanes; l++) begin : g_lane
		nwl_square u_sq (
			.clk  (clk),
			.adv  (adv),
			.comp (s_axis_tdata[l*CompW +: CompW]),
			.mag  (mag[l]),
			.neg  (neg[l]),
			.sq_s1(sq_s1[l])
		);
		nwl_divide u_div (
			.clk (clk),
			.adv (adv),
			.mag (magd_q[PreDiv-1][l]),
			.len (root),
			.quot(quot[l])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			for (int l = 0; l < Lanes; l++) begin
				magd_q[0][l] <= mag[l];
				negd_q[0][l] <= neg[l];
			end
			for (int k = 1; k < PreDiv; k++) begin
				magd_q[k] <= magd_q[k-1];
			end
			for (int k = 1; k < TotalLat; k++) begin
				negd_q[k] <= negd_q[k-1];
			end
			lend_q[0] <= root;
			for (int k = 1; k < DivLat; k++) begin
				lend_q[k] <= lend_q[k-1];
			end
		end
	end

	nwl_sqrt u_sqrt (
		.clk     (clk),
		.adv     (adv),
		.radicand(sum_s2),
		.root    (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TotalLat; k++) begin
				vld_q[k] <= 1'b0;
			end
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= s_axis_tvalid;
			for (int k = 1; k < TotalLat; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
			out_vld_q <= vld_q[TotalLat-1];
		end
	end

	// Merge the lanes: apply the sign and the zero-length rule.
	assign zero_o = lend_q[DivLat-1] <= RootW'(thr_q);
	always_comb begin
		for (int l = 0; l < Lanes; l++) begin
			if (zero_o) begin
				unit_o[l] = '0;
			end else if (negd_q[TotalLat-1][l]) begin
				unit_o[l] = UnitW'(0) - UnitW'(quot[l]);
			end else begin
				unit_o[l] = UnitW'(quot[l]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {2'b00, lend_q[DivLat-1], unit_o[2], unit_o[1], unit_o[0]};
			out_zero_q <= zero_o;
		end
	end

	assign m_axis_tvalid   = out_vld_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_zero_q;
endmodule

[tb/vec3_normalise_with_length_tb.sv]
`timescale 1ns / 1ps

module vec3_normalise_with_length_tb;
	import nwl_pkg::*;

	typedef struct packed {
		logic [17:0] ux;
		logic [17:0] uy;
		logic [17:0] uz;
		logic [31:0] len;
		logic        zflag;
	} norm_res_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [87:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	norm_res_t   expected_q[$];
	logic [15:0] threshold;
	int          errors;
	int          results_seen;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_cycles;

	vec3_normalise_with_length i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("vec3_normalise_with_length: mismatch");
		$finish;
	end

	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic logic [17:0] unit_of(input logic [31:0] c, input logic [31:0] len);
		logic [63:0] mag;
		logic [63:0] quot;
		mag = c[31] ? {32'd0, (~c) + 32'd1} : {32'd0, c};
		if (c == 32'h8000_0000) mag = 64'h8000_0000;
		quot = (mag << FracBits) / {32'd0, len};
		if (quot > 64'd65536) quot = 64'd65536;
		return c[31] ? 18'(-quot) : 18'(quot);
	endfunction

	function automatic norm_res_t normalise(input logic [95:0] v);
		norm_res_t r;
		logic [63:0] mx, my, mz, len;
		mx = v[31] ? 64'(-$signed({1'b1, v[31:0]})) : 64'(v[31:0]);
		my = v[63] ? 64'(-$signed({1'b1, v[63:32]})) : 64'(v[63:32]);
		mz = v[95] ? 64'(-$signed({1'b1, v[95:64]})) : 64'(v[95:64]);
		len = isqrt(mx * mx + my * my + mz * mz);
		r.len = len[31:0];
		if (len <= {48'd0, threshold}) begin
			r.ux = 0; r.uy = 0; r.uz = 0; r.zflag = 1'b1;
		end else begin
			r.ux = unit_of(v[31:0], r.len);
			r.uy = unit_of(v[63:32], r.len);
			r.uz = unit_of(v[95:64], r.len);
			r.zflag = 1'b0;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("result %0d: %s got %h expected %h", results_seen, what, got, want);
		errors++;
	endtask

	// Receiver side: random stalls plus an optional long hold-off.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		norm_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_q.size() == 0) begin
				$display("result %0d arrived with nothing expected", results_seen);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (m_axis_tdata[17:0] !== want.ux)
					report_mismatch("unit_x", 32'(m_axis_tdata[17:0]), 32'(want.ux));
				if (m_axis_tdata[35:18] !== want.uy)
					report_mismatch("unit_y", 32'(m_axis_tdata[35:18]), 32'(want.uy));
				if (m_axis_tdata[53:36] !== want.uz)
					report_mismatch("unit_z", 32'(m_axis_tdata[53:36]), 32'(want.uz));
				if (m_axis_tdata[85:54] !== want.len)
					report_mismatch("vec_length", m_axis_tdata[85:54], want.len);
				if (m_axis_tuser[0] !== want.zflag)
					report_mismatch("zero_flag", 32'(m_axis_tuser[0]), 32'(want.zflag));
			end
			results_seen++;
		end
	end

	// Valid stays high after an accepted request so that requests can follow
	// back to back; idle cycles and drain() take it low.
	task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {z, y, x};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_q.push_back(normalise({z, y, x}));
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (TotalLat + 8) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [15:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		threshold = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(5))
			0: return $urandom();
			1: return 32'($signed($urandom_range(200)) - 100);
			2: return 32'($signed($urandom_range(131072)) - 65536);
			3: return {{12{1'($urandom_range(1))}}, 20'($urandom())};
			4: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: return 32'($signed($urandom_range(20000000)) - 10000000);
		endcase
	endfunction

	task automatic test_directed();
		send_vector(0, 0, 0);
		send_vector(32'h0001_0000, 0, 0);
		send_vector(0, 32'hFFFF_0000, 0);
		send_vector(0, 0, 32'h0001_0000);
		send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_vector(32'h8000_0000, 0, 0);
		send_vector(32'h7FFF_FFFF, 0, 0);
		send_vector(66, 0, 0);
		send_vector(67, 0, 0);
		send_vector(32'hFFFF_FFBE, 0, 0);
		send_vector(1, 1, 1);
		send_vector(32'h0003_0000, 32'h0004_0000, 0);
		send_vector(32'hFFFD_0000, 32'h0004_0000, 32'hFFFF_FFFF);
		send_vector(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_thresholds();
		write_threshold(16'd0);
		send_vector(0, 0, 0);
		send_vector(1, 0, 0);
		send_vector(32'hFFFF_FFFF, 0, 0);
		write_threshold(16'hFFFF);
		send_vector(32'h0000_FFFF, 0, 0);
		send_vector(32'h0001_0000, 0, 0);
		send_vector(32'hFFFF_0001, 0, 0);
		repeat (40) send_vector(rand_comp(), rand_comp(), rand_comp());
		write_threshold(16'h5A5A);
		repeat (40) send_vector(rand_comp(), rand_comp(), rand_comp());
		write_threshold(16'd66);
	endtask

	task automatic test_random(input int count);
		repeat (count) send_vector(rand_comp(), rand_comp(), rand_comp());
	endtask

	// The receiver stops for a long stretch while requests keep coming, so the
	// pipeline fills and the input stalls; then the sender waits for the drain.
	task automatic test_backpressure();
		send_idle_pct = 0;
		hold_cycles = 300;
		test_random(120);
		drain();
		test_random(20);
	endtask

	initial begin
		errors = 0;
		results_seen = 0;
		hold_cycles = 0;
		threshold = ThrReset;
		send_idle_pct = 28;
		recv_idle_pct = 74;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(200);
		test_thresholds();
		send_idle_pct = 74;
		recv_idle_pct = 28;
		test_random(150);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(150);
		test_backpressure();
		drain();

		$display("Covered axis extremes, near-zero vectors, thresholds 0, 66, 0x5A5A, 0xFFFF,");
		$display("%0d results under mixed stalls and a long output hold-off.", results_seen);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("vec3_normalise_with_length: match");
		end else begin
			$display("vec3_normalise_with_length: mismatch");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/nwl_pkg.sv
hw/rtl/nwl_square.sv
hw/rtl/nwl_sqrt.sv
hw/rtl/nwl_divide.sv
hw/rtl/vec3_normalise_with_length.sv
tb/vec3_normalise_with_length_tb.sv
